>>> sv/xsf_pkg.sv
// Shared constants, opcodes and types of the XOR sprite framebuffer.
`default_nettype none

package xsf_pkg;

  // Screen size; both must be powers of two (8 to 64).
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  // A row word is always 64 bits wide; columns at or past the width stay zero.
  localparam int ROW_W     = 64;
  localparam int SPRITE_W  = 8;
  localparam int COL_W     = $clog2(SCREEN_WIDTH);
  localparam int ROW_AW    = $clog2(SCREEN_HEIGHT);
  localparam int ROWIDX_W  = 5;
  // Origin row plus row index, wide enough to hold the sum without wrapping.
  localparam int SUM_W     = ((ROW_AW > ROWIDX_W) ? ROW_AW : ROWIDX_W) + 1;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef logic [ROW_W-1:0] row_t;

endpackage

`default_nettype wire

>>> sv/xsf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module xsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/xsf_mask.sv
// Turns one sprite row and its origin column into a clipped 64-bit row mask.
`default_nettype none

module xsf_mask (
  input  wire logic [xsf_pkg::COL_W-1:0]    col,
  input  wire logic [xsf_pkg::SPRITE_W-1:0] bits,
  output xsf_pkg::row_t                     mask
);
  import xsf_pkg::*;

  logic [SPRITE_W-1:0]       bits_rev;
  logic [ROW_W+SPRITE_W-1:0] shifted;
  row_t                      visible;

  // Bit 7 of the sprite row lands on the origin column, so reverse it first.
  always_comb begin
    for (int j = 0; j < SPRITE_W; j++) begin
      bits_rev[j] = bits[SPRITE_W-1-j];
    end
  end

  // Columns at or past the screen width fall outside the visible range.
  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      visible[c] = (c < SCREEN_WIDTH);
    end
  end

  assign shifted = {{ROW_W{1'b0}}, bits_rev} << col;
  assign mask    = shifted[ROW_W-1:0] & visible;

endmodule

`default_nettype wire

>>> sv/xor_sprite_framebuffer_top.sv
// Top level of the XOR sprite framebuffer with collision detection.
//
//   Channel  Handshake           Payload
//   -------  ------------------  ----------------------------------------------
//   in       in_valid/in_ready   opcode, pos_x, pos_y, row_index, row_bits,
//                                last_row
//   out      out_valid/out_ready collision, row_pixels
//
// Every item passes through S_IDLE and S_EXEC: the cycle it is accepted
// issues the read of its row from the row memory, and S_EXEC then XORs the
// sprite mask into the read data and writes the row back (draws only) and
// loads the result register. A clear takes no longer than any other item,
// since a valid flag per row stands in for the memory contents; reset
// clears the flags and the collision bit at once. A result waiting in
// the output register does not block the next item from being accepted;
// the block only stalls in S_EXEC if the previous result has not been taken.
`default_nettype none

module xor_sprite_framebuffer_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     opcode,
  input  wire logic [7:0]                     pos_x,
  input  wire logic [7:0]                     pos_y,
  input  wire logic [xsf_pkg::ROWIDX_W-1:0]   row_index,
  input  wire logic [xsf_pkg::SPRITE_W-1:0]   row_bits,
  input  wire logic                           last_row,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                collision,
  output xsf_pkg::row_t                       row_pixels
);
  import xsf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;

  // Fields of the item in flight.
  logic [1:0]          op_q;
  logic                last_q;
  logic                skip_q;
  logic [SPRITE_W-1:0] bits_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_AW-1:0]   row_q;

  // One flag per row: a row whose flag is low reads as all pixels off.
  logic [SCREEN_HEIGHT-1:0] row_valid;
  logic                     coll_acc;

  logic              accept;
  logic              finish;
  logic [ROW_AW-1:0] py_mod;
  logic [SUM_W-1:0]  target;
  logic [ROW_AW-1:0] rd_addr;
  row_t              ram_q;
  row_t              cur_row;
  row_t              mask;
  logic              hit;
  logic              coll_draw;
  logic              wr_en;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // The S_EXEC state completes once the output register is free or emptying.
  assign finish   = (state == S_EXEC) && (!out_valid || out_ready);

  // Target row of a draw; the origin is reduced, the row index is not.
  assign py_mod  = ROW_AW'(pos_y % SCREEN_HEIGHT);
  assign target  = SUM_W'(py_mod) + SUM_W'(row_index);
  assign rd_addr = (opcode == OP_DRAW) ? target[ROW_AW-1:0] : py_mod;

  xsf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SCREEN_HEIGHT)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (row_q),
    .wdata (cur_row ^ mask),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  xsf_mask u_mask (
    .col  (col_q),
    .bits (bits_q),
    .mask (mask)
  );

  // The read data holds until the next accept, so it stays good while stalled.
  assign cur_row   = row_valid[row_q] ? ram_q : '0;
  assign hit       = |(cur_row & mask);
  assign coll_draw = coll_acc || (hit && !skip_q);
  assign wr_en     = finish && (op_q == OP_DRAW) && !skip_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      last_q <= last_row;
      skip_q <= (target >= SUM_W'(SCREEN_HEIGHT));
      bits_q <= row_bits;
      col_q  <= COL_W'(pos_x % SCREEN_WIDTH);
      row_q  <= rd_addr;
    end
  end

  // Sequencer, row flags and collision accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      coll_acc  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (finish) begin
            state <= S_IDLE;
            case (op_q)
              OP_CLEAR: begin
                row_valid <= '0;
                coll_acc  <= 1'b0;
              end
              OP_DRAW: begin
                if (!skip_q) begin
                  row_valid[row_q] <= 1'b1;
                end
                // The result carries this row's hit; on the last row the sprite ends here.
                coll_acc <= last_q ? 1'b0 : coll_draw;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      case (op_q)
        OP_CLEAR: begin
          collision  <= 1'b0;
          row_pixels <= '0;
        end
        OP_DRAW: begin
          collision  <= coll_draw;
          row_pixels <= '0;
        end
        OP_READ: begin
          collision  <= coll_acc;
          row_pixels <= cur_row;
        end
        default: begin
          collision  <= coll_acc;
          row_pixels <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/xsf_checker.sv
// Port-level checks of the framebuffer top, bound onto it.
`default_nettype none

module xsf_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [1:0]                   opcode,
  input wire logic [7:0]                   pos_x,
  input wire logic [7:0]                   pos_y,
  input wire logic [xsf_pkg::ROWIDX_W-1:0] row_index,
  input wire logic [xsf_pkg::SPRITE_W-1:0] row_bits,
  input wire logic                         last_row,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         collision,
  input wire xsf_pkg::row_t                row_pixels
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_pixels) && $stable(collision))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("item accepted while another is at work");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an accepted item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items outstanding");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind xor_sprite_framebuffer_top xsf_checker u_xsf_checker (.*);

`default_nettype wire
